// ----- src/spvd_pkg.sv -----
// Shared types, constants and decode functions for the signed prefix varint decoder.
// Depends on nothing; used by spvd_frame_step and signed_prefix_varint_decoder.
package spvd_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned ValueWidth = 64;
   localparam int unsigned LenWidth   = 4;

   // Frames whose first byte is 0xFE or 0xFF carry eight raw bytes after the prefix.
   localparam logic [LenWidth-1:0] RawFrameLen   = 4'd9;
   localparam logic [LenWidth-1:0] RawPayloadLen = 4'd8;

   typedef struct packed {
      logic [LenWidth-1:0]   bytes_left;
      logic [LenWidth-1:0]   frame_len;
      logic [ValueWidth-1:0] accumulator;
   } spvd_state_type;

   typedef struct packed {
      logic                  emit;
      logic [ValueWidth-1:0] value;
      logic [LenWidth-1:0]   frame_length;
   } spvd_result_type;

   // The run of leading ones in the first byte gives the frame length.
   function automatic logic [LenWidth-1:0] lead_len(input logic [ByteWidth-1:0] first);
      logic [LenWidth-1:0] len;
      unique casez (first)
         8'b0???????: len = 4'd1;
         8'b10??????: len = 4'd2;
         8'b110?????: len = 4'd3;
         8'b1110????: len = 4'd4;
         8'b11110???: len = 4'd5;
         8'b111110??: len = 4'd6;
         8'b1111110?: len = 4'd7;
         default:     len = RawFrameLen;
      endcase
      return len;
   endfunction

   // Sign-extends a 7*len bit value; raw frames pass through unchanged.
   function automatic logic [ValueWidth-1:0] sign_extend(input logic [ValueWidth-1:0] acc,
                                                         input logic [LenWidth-1:0]   len);
      logic [ValueWidth-1:0] result;
      case (len)
         4'd1:    result = {{57{acc[6]}},  acc[6:0]};
         4'd2:    result = {{50{acc[13]}}, acc[13:0]};
         4'd3:    result = {{43{acc[20]}}, acc[20:0]};
         4'd4:    result = {{36{acc[27]}}, acc[27:0]};
         4'd5:    result = {{29{acc[34]}}, acc[34:0]};
         4'd6:    result = {{22{acc[41]}}, acc[41:0]};
         4'd7:    result = {{15{acc[48]}}, acc[48:0]};
         default: result = acc;
      endcase
      return result;
   endfunction

endpackage

// ----- src/spvd_frame_step.sv -----
// Per-byte decode step: next frame state and the finished value, if any.
// Depends on spvd_pkg for the state and result types and the decode functions.
module spvd_frame_step (
   input  logic [spvd_pkg::ByteWidth-1:0] in_byte,
   input  spvd_pkg::spvd_state_type       state_cur,
   output spvd_pkg::spvd_state_type       state_next,
   output spvd_pkg::spvd_result_type      result
);

   logic [spvd_pkg::LenWidth-1:0]   first_len;
   logic [spvd_pkg::ByteWidth-1:0]  first_mask;
   logic [spvd_pkg::ValueWidth-1:0] acc_new;
   logic [spvd_pkg::LenWidth-1:0]   left_new;
   logic [spvd_pkg::LenWidth-1:0]   len_new;
   logic                            last_byte;

   assign first_len  = spvd_pkg::lead_len(in_byte);
   assign first_mask = spvd_pkg::ByteWidth'(8'hFF >> first_len);

   always_comb begin
      if (state_cur.bytes_left == '0) begin
         len_new = first_len;
         if (first_len == spvd_pkg::RawFrameLen) begin
            acc_new   = '0;
            left_new  = spvd_pkg::RawPayloadLen;
            last_byte = 1'b0;
         end else begin
            acc_new   = {{(spvd_pkg::ValueWidth-spvd_pkg::ByteWidth){1'b0}},
                         in_byte & first_mask};
            left_new  = first_len - 4'd1;
            last_byte = (first_len == 4'd1);
         end
      end else begin
         len_new   = state_cur.frame_len;
         acc_new   = {state_cur.accumulator[spvd_pkg::ValueWidth-spvd_pkg::ByteWidth-1:0],
                      in_byte};
         left_new  = state_cur.bytes_left - 4'd1;
         last_byte = (state_cur.bytes_left == 4'd1);
      end
   end

   always_comb begin
      result.emit         = last_byte;
      result.value        = spvd_pkg::sign_extend(acc_new, len_new);
      result.frame_length = len_new;
      state_next.frame_len = len_new;
      if (last_byte) begin
         state_next.bytes_left  = '0;
         state_next.accumulator = '0;
      end else begin
         state_next.bytes_left  = left_new;
         state_next.accumulator = acc_new;
      end
   end

endmodule

// ----- src/signed_prefix_varint_decoder.sv -----
// Top level of the signed prefix varint decoder: input register, frame state, result register.
// Depends on spvd_pkg and spvd_frame_step.

// The decoder takes one wire byte per transfer and returns one transfer carrying the
// sign-extended 64-bit value and the frame length (1 to 9) on the last byte of each frame;
// other bytes return nothing. It sustains one byte per clock except when a byte is held back
// as below: a byte is registered, then the combinational decode step between the input
// register and the frame state register finishes it, and the result is registered in the
// result register, from which it is presented and can itself transfer.
// The result register lets the next bytes flow while a finished value waits; a byte is held
// back only when it would finish a frame while the previous result is still stalled.
module signed_prefix_varint_decoder (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [spvd_pkg::ByteWidth-1:0]        req_in_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [spvd_pkg::ValueWidth-1:0] rsp_value,
   output logic [spvd_pkg::LenWidth-1:0]         rsp_frame_length
);

   logic                            in_valid_ff;
   logic [spvd_pkg::ByteWidth-1:0]  in_byte_ff;
   spvd_pkg::spvd_state_type        state_ff;
   spvd_pkg::spvd_state_type        state_in;
   spvd_pkg::spvd_result_type       step_result;
   logic                            rsp_valid_ff;
   logic [spvd_pkg::ValueWidth-1:0] rsp_value_ff;
   logic [spvd_pkg::LenWidth-1:0]   rsp_len_ff;
   logic                            advance;
   logic                            load_rsp;

   spvd_frame_step u_step (
      .in_byte    (in_byte_ff),
      .state_cur  (state_ff),
      .state_next (state_in),
      .result     (step_result)
   );

   // A byte that finishes no frame never needs the result register.
   assign advance   = in_valid_ff && (!step_result.emit || !rsp_valid_ff || !rsp_stall);
   assign load_rsp  = advance && step_result.emit;
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            state_ff <= state_in;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_in_byte;
      end
      if (load_rsp) begin
         rsp_value_ff <= step_result.value;
         rsp_len_ff   <= step_result.frame_length;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_value        = rsp_value_ff;
   assign rsp_frame_length = rsp_len_ff;

   // A waiting result is never overwritten by a new one.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !load_rsp)
      else $error("result register overwritten while stalled");

   // Bytes still due always stay below the frame length.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff.bytes_left != '0) |-> (state_ff.bytes_left < state_ff.frame_len))
      else $error("bytes_left out of range for frame length");

   // Every result reports a legal frame length.
   assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> (step_result.frame_length != '0 &&
                    step_result.frame_length <= spvd_pkg::RawFrameLen))
      else $error("illegal frame length on result");

   // A held byte stays in the input register until it advances.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("stalled input byte lost");

endmodule
